// File: rtl/color_gradient_evaluator_core_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the colour gradient evaluator core
// Shorthand for clocked implication checks with a synchronous reset.
// ---------------------------------------------------------------------------
`ifndef COLOR_GRADIENT_EVALUATOR_CORE_ASSERT_SVH
`define COLOR_GRADIENT_EVALUATOR_CORE_ASSERT_SVH

// same-cycle implication
`define CGE_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define CGE_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: rtl/cge_pkg.sv
// ---------------------------------------------------------------------------
// cge_pkg
// Shared constants, types and helpers of the colour gradient evaluator.
// ---------------------------------------------------------------------------
package cge_pkg;

   localparam int MARK_COUNT    = 8;
   localparam int POSITION_BITS = 16;
   localparam int SLOT_BITS     = (MARK_COUNT > 1) ? $clog2(MARK_COUNT) : 1;
   localparam int CHAN_BITS     = 8;
   localparam int COLOR_BITS    = 4 * CHAN_BITS;
   // a*(d-n) + b*n <= 255*d
   localparam int NUM_BITS      = POSITION_BITS + CHAN_BITS;
   // 2*num + d <= 511*d
   localparam int DIV_BITS      = POSITION_BITS + CHAN_BITS + 1;
   localparam int FIFO_DEPTH    = 2;
   localparam int FIFO_PTR_BITS = 1;
   localparam int FIFO_CNT_BITS = 2;

   localparam logic [SLOT_BITS-1:0] LAST_SLOT = SLOT_BITS'(MARK_COUNT - 1);

   localparam logic ACT_WRITE = 1'b0;
   localparam logic ACT_QUERY = 1'b1;

   localparam logic [1:0] KIND_INTERP = 2'd0;
   localparam logic [1:0] KIND_SINGLE = 2'd1;
   localparam logic [1:0] KIND_BLACK  = 2'd2;

   localparam logic [COLOR_BITS-1:0] BLACK_OPAQUE = 32'hFF00_0000;
   localparam logic [COLOR_BITS-1:0] WHITE_OPAQUE = 32'hFFFF_FFFF;

   localparam logic [1:0] CH_RED   = 2'd0;
   localparam logic [1:0] CH_GREEN = 2'd1;
   localparam logic [1:0] CH_BLUE  = 2'd2;
   localparam logic [1:0] CH_ALPHA = 2'd3;

   typedef struct packed {
      logic                     is_query;
      logic                     slot_ok;
      logic [SLOT_BITS-1:0]     slot;
      logic [POSITION_BITS-1:0] pos;
      logic                     enable;
      logic [COLOR_BITS-1:0]    color;
   } item_type;

   typedef struct packed {
      logic empty;
      logic full;
   } fifo_status_type;

   function automatic logic [CHAN_BITS-1:0] chan_of(input logic [COLOR_BITS-1:0] color,
                                                    input logic [1:0] ch);
      logic [CHAN_BITS-1:0] res;
      case (ch)
         CH_RED:   res = color[7:0];
         CH_GREEN: res = color[15:8];
         CH_BLUE:  res = color[23:16];
         CH_ALPHA: res = color[31:24];
         default:  res = color[7:0];
      endcase
      return res;
   endfunction

endpackage

// File: rtl/color_gradient_evaluator_core.sv
// ---------------------------------------------------------------------------
// color_gradient_evaluator_core
// Piecewise linear colour ramp over a small table of gradient marks.
// ---------------------------------------------------------------------------
//
//   channel   handshake          payload
//   request   start / busy       req_action, req_mark_slot, req_position,
//                                req_mark_enable, req_{red,green,blue,alpha}_in
//   result    rsp_valid strobe   rsp_{red,green,blue,alpha}_out, rsp_source_kind
//
// A request is taken when start is high and busy low and waits in a two-deep queue.
// A write updates the table once the idle back end pops it. A query scans one slot per cycle and
// strobes after the scan with one side or none, or after interpolation when it has both sides:
// four channels of one multiply plus eight divider steps. busy is high while the queue is full;
// rsp_valid lasts one cycle and cannot be stalled. Synchronous reset: black at 0, white at full
// scale, queue empty.
//
module color_gradient_evaluator_core import cge_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic        req_action,
   input  logic [2:0]  req_mark_slot,
   input  logic [15:0] req_position,
   input  logic        req_mark_enable,
   input  logic [7:0]  req_red_in,
   input  logic [7:0]  req_green_in,
   input  logic [7:0]  req_blue_in,
   input  logic [7:0]  req_alpha_in,
   output logic        rsp_valid,
   output logic [7:0]  rsp_red_out,
   output logic [7:0]  rsp_green_out,
   output logic [7:0]  rsp_blue_out,
   output logic [7:0]  rsp_alpha_out,
   output logic [1:0]  rsp_source_kind
);

   fifo_status_type       fifo_status;
   item_type              front_item;
   item_type              head_item;
   logic                  push;
   logic                  pop;
   logic [COLOR_BITS-1:0] rsp_color;

   // front end: classify and enqueue
   cge_front u_front (
      .start           (start),
      .req_action      (req_action),
      .req_mark_slot   (req_mark_slot),
      .req_position    (req_position),
      .req_mark_enable (req_mark_enable),
      .req_red_in      (req_red_in),
      .req_green_in    (req_green_in),
      .req_blue_in     (req_blue_in),
      .req_alpha_in    (req_alpha_in),
      .fifo_status     (fifo_status),
      .busy            (busy),
      .push            (push),
      .item            (front_item)
   );

   // queue keeps request order, so writes and queries stay in sequence
   cge_fifo u_fifo (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .item_in  (front_item),
      .pop      (pop),
      .item_out (head_item),
      .status   (fifo_status)
   );

   // back end: table, scan, interpolation
   cge_back u_back (
      .clock       (clock),
      .reset       (reset),
      .head        (head_item),
      .fifo_status (fifo_status),
      .pop         (pop),
      .rsp_valid   (rsp_valid),
      .rsp_color   (rsp_color),
      .rsp_kind    (rsp_source_kind)
   );

   assign rsp_red_out   = rsp_color[7:0];
   assign rsp_green_out = rsp_color[15:8];
   assign rsp_blue_out  = rsp_color[23:16];
   assign rsp_alpha_out = rsp_color[31:24];

endmodule

// File: rtl/cge_front.sv
// ---------------------------------------------------------------------------
// cge_front
// Takes requests, sorts writes from queries and pushes them to the queue.
// ---------------------------------------------------------------------------
module cge_front import cge_pkg::*; (
   input  logic            start,
   input  logic            req_action,
   input  logic [2:0]      req_mark_slot,
   input  logic [15:0]     req_position,
   input  logic            req_mark_enable,
   input  logic [7:0]      req_red_in,
   input  logic [7:0]      req_green_in,
   input  logic [7:0]      req_blue_in,
   input  logic [7:0]      req_alpha_in,
   input  fifo_status_type fifo_status,
   output logic            busy,
   output logic            push,
   output item_type        item
);

   assign busy = fifo_status.full;
   assign push = start && !fifo_status.full;

   always_comb begin
      item.is_query = (req_action == ACT_QUERY);
      // slots past the table are dropped by the back end
      item.slot_ok  = (int'(req_mark_slot) < MARK_COUNT);
      item.slot     = SLOT_BITS'(req_mark_slot);
      item.pos      = POSITION_BITS'(req_position);
      item.enable   = req_mark_enable;
      item.color    = {req_alpha_in, req_blue_in, req_green_in, req_red_in};
   end

endmodule

// File: rtl/cge_fifo.sv
// ---------------------------------------------------------------------------
// cge_fifo
// Two-entry request queue between front and back end.
// ---------------------------------------------------------------------------
module cge_fifo import cge_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            push,
   input  item_type        item_in,
   input  logic            pop,
   output item_type        item_out,
   output fifo_status_type status
);

   item_type                 mem_ff [FIFO_DEPTH];
   logic [FIFO_PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [FIFO_PTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [FIFO_CNT_BITS-1:0] count_ff, count_in;

   assign status.empty = (count_ff == '0);
   assign status.full  = (count_ff == FIFO_CNT_BITS'(FIFO_DEPTH));
   assign item_out     = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + FIFO_CNT_BITS'(push) - FIFO_CNT_BITS'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= item_in;
      end
   end

endmodule

// File: rtl/cge_back.sv
// ---------------------------------------------------------------------------
// cge_back
// Mark table, serial scan, and per-channel interpolation with a shared divider.
// ---------------------------------------------------------------------------
module cge_back import cge_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  item_type              head,
   input  fifo_status_type       fifo_status,
   output logic                  pop,
   output logic                  rsp_valid,
   output logic [COLOR_BITS-1:0] rsp_color,
   output logic [1:0]            rsp_kind
);

   localparam logic [2:0] ST_IDLE    = 3'd0;
   localparam logic [2:0] ST_SCAN    = 3'd1;
   localparam logic [2:0] ST_RESOLVE = 3'd2;
   localparam logic [2:0] ST_MUL     = 3'd3;
   localparam logic [2:0] ST_DIV     = 3'd4;

   // mark table
   logic                     valid_ff [MARK_COUNT];
   logic [POSITION_BITS-1:0] pos_ff   [MARK_COUNT];
   logic [COLOR_BITS-1:0]    color_ff [MARK_COUNT];

   logic [2:0]               state_ff, state_in;
   logic [POSITION_BITS-1:0] qpos_ff, qpos_in;
   logic [SLOT_BITS-1:0]     idx_ff, idx_in;
   logic                     lo_found_ff, lo_found_in, hi_found_ff, hi_found_in;
   logic [POSITION_BITS-1:0] lo_pos_ff, lo_pos_in, hi_pos_ff, hi_pos_in;
   logic [COLOR_BITS-1:0]    lo_color_ff, lo_color_in, hi_color_ff, hi_color_in;
   logic [POSITION_BITS-1:0] d_ff, d_in, n_ff, n_in;
   logic [1:0]               ch_ff, ch_in;
   logic [DIV_BITS-1:0]      rem_ff, rem_in, dvs_ff, dvs_in;
   logic [2:0]               step_ff, step_in;
   logic [CHAN_BITS-1:0]     quo_ff, quo_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [COLOR_BITS-1:0]    rsp_color_ff, rsp_color_in;
   logic [1:0]               rsp_kind_ff, rsp_kind_in;

   logic                     tbl_we;
   logic                     mv;
   logic [POSITION_BITS-1:0] mp;
   logic [CHAN_BITS-1:0]     chan_lo, chan_hi;
   logic [NUM_BITS-1:0]      prod_lo, prod_hi, num;
   logic                     ge;
   logic [CHAN_BITS-1:0]     quo_next;

   assign pop       = (state_ff == ST_IDLE) && !fifo_status.empty;
   assign tbl_we    = pop && !head.is_query && head.slot_ok;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_color = rsp_color_ff;
   assign rsp_kind  = rsp_kind_ff;

   assign mv = valid_ff[idx_ff];
   assign mp = pos_ff[idx_ff];

   assign chan_lo = chan_of(lo_color_ff, ch_ff);
   assign chan_hi = chan_of(hi_color_ff, ch_ff);
   assign prod_lo = NUM_BITS'(chan_lo) * NUM_BITS'(d_ff - n_ff);
   assign prod_hi = NUM_BITS'(chan_hi) * NUM_BITS'(n_ff);
   assign num     = prod_lo + prod_hi;

   assign ge       = (rem_ff >= dvs_ff);
   assign quo_next = {quo_ff[CHAN_BITS-2:0], ge};

   always_comb begin
      state_in     = state_ff;
      qpos_in      = qpos_ff;
      idx_in       = idx_ff;
      lo_found_in  = lo_found_ff;
      hi_found_in  = hi_found_ff;
      lo_pos_in    = lo_pos_ff;
      hi_pos_in    = hi_pos_ff;
      lo_color_in  = lo_color_ff;
      hi_color_in  = hi_color_ff;
      d_in         = d_ff;
      n_in         = n_ff;
      ch_in        = ch_ff;
      rem_in       = rem_ff;
      dvs_in       = dvs_ff;
      step_in      = step_ff;
      quo_in       = quo_ff;
      rsp_valid_in = 1'b0;
      rsp_color_in = rsp_color_ff;
      rsp_kind_in  = rsp_kind_ff;

      case (state_ff)
         ST_IDLE: begin
            if (pop && head.is_query) begin
               qpos_in     = head.pos;
               idx_in      = '0;
               lo_found_in = 1'b0;
               hi_found_in = 1'b0;
               state_in    = ST_SCAN;
            end
         end
         ST_SCAN: begin
            // strict compares keep the lowest slot on equal positions
            if (mv && (mp > qpos_ff) && (!hi_found_ff || (mp < hi_pos_ff))) begin
               hi_found_in = 1'b1;
               hi_pos_in   = mp;
               hi_color_in = color_ff[idx_ff];
            end
            if (mv && (mp < qpos_ff) && (!lo_found_ff || (mp > lo_pos_ff))) begin
               lo_found_in = 1'b1;
               lo_pos_in   = mp;
               lo_color_in = color_ff[idx_ff];
            end
            if (idx_ff == LAST_SLOT) begin
               state_in = ST_RESOLVE;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         ST_RESOLVE: begin
            if (lo_found_ff && hi_found_ff) begin
               d_in     = hi_pos_ff - lo_pos_ff;
               n_in     = qpos_ff - lo_pos_ff;
               ch_in    = CH_RED;
               state_in = ST_MUL;
            end else begin
               rsp_valid_in = 1'b1;
               rsp_kind_in  = KIND_SINGLE;
               if (hi_found_ff) begin
                  rsp_color_in = hi_color_ff;
               end else if (lo_found_ff) begin
                  rsp_color_in = lo_color_ff;
               end else begin
                  rsp_color_in = BLACK_OPAQUE;
                  rsp_kind_in  = KIND_BLACK;
               end
               state_in = ST_IDLE;
            end
         end
         ST_MUL: begin
            // dividend 2*num + d, divisor 2*d aligned to the top quotient bit
            rem_in   = {num, 1'b0} + DIV_BITS'(d_ff);
            dvs_in   = DIV_BITS'({d_ff, {CHAN_BITS{1'b0}}});
            step_in  = '0;
            quo_in   = '0;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            if (ge) begin
               rem_in = rem_ff - dvs_ff;
            end
            dvs_in  = dvs_ff >> 1;
            quo_in  = quo_next;
            step_in = step_ff + 1'b1;
            if (step_ff == 3'd7) begin
               case (ch_ff)
                  CH_RED:   rsp_color_in[7:0]   = quo_next;
                  CH_GREEN: rsp_color_in[15:8]  = quo_next;
                  CH_BLUE:  rsp_color_in[23:16] = quo_next;
                  CH_ALPHA: rsp_color_in[31:24] = quo_next;
                  default:  rsp_color_in[7:0]   = quo_next;
               endcase
               if (ch_ff == CH_ALPHA) begin
                  rsp_valid_in = 1'b1;
                  rsp_kind_in  = KIND_INTERP;
                  state_in     = ST_IDLE;
               end else begin
                  ch_in    = ch_ff + 1'b1;
                  state_in = ST_MUL;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      qpos_ff      <= qpos_in;
      idx_ff       <= idx_in;
      lo_found_ff  <= lo_found_in;
      hi_found_ff  <= hi_found_in;
      lo_pos_ff    <= lo_pos_in;
      hi_pos_ff    <= hi_pos_in;
      lo_color_ff  <= lo_color_in;
      hi_color_ff  <= hi_color_in;
      d_ff         <= d_in;
      n_ff         <= n_in;
      ch_ff        <= ch_in;
      rem_ff       <= rem_in;
      dvs_ff       <= dvs_in;
      step_ff      <= step_in;
      quo_ff       <= quo_in;
      rsp_color_ff <= rsp_color_in;
      rsp_kind_ff  <= rsp_kind_in;
   end

   // table: black at 0 and white at full scale after reset
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < MARK_COUNT; i++) begin
            valid_ff[i] <= (i < 2);
            pos_ff[i]   <= (i == 1) ? {POSITION_BITS{1'b1}} : '0;
            color_ff[i] <= (i == 0) ? BLACK_OPAQUE : ((i == 1) ? WHITE_OPAQUE : '0);
         end
      end else if (tbl_we) begin
         valid_ff[head.slot] <= head.enable;
         pos_ff[head.slot]   <= head.pos;
         color_ff[head.slot] <= head.color;
      end
   end

endmodule

// File: rtl/cge_checker.sv
// ---------------------------------------------------------------------------
// cge_checker
// Port-level checks on the colour gradient evaluator core.
// ---------------------------------------------------------------------------
`include "color_gradient_evaluator_core_assert.svh"

module cge_checker import cge_pkg::*; (
   input logic       clock,
   input logic       reset,
   input logic       busy,
   input logic       rsp_valid,
   input logic [7:0] rsp_red_out,
   input logic [7:0] rsp_green_out,
   input logic [7:0] rsp_blue_out,
   input logic [7:0] rsp_alpha_out,
   input logic [1:0] rsp_source_kind
);

   logic kind_ok;
   logic black_rsp;
   logic is_black;

   assign kind_ok   = (rsp_source_kind == KIND_INTERP) || (rsp_source_kind == KIND_SINGLE)
                      || (rsp_source_kind == KIND_BLACK);
   assign black_rsp = rsp_valid && (rsp_source_kind == KIND_BLACK);
   assign is_black  = (rsp_red_out == 8'd0) && (rsp_green_out == 8'd0)
                      && (rsp_blue_out == 8'd0) && (rsp_alpha_out == 8'hFF);

   `CGE_ASSERT_NEXT(a_rsp_spaced, clock, reset, rsp_valid, !rsp_valid, "back-to-back results")
   `CGE_ASSERT_IMPL(a_kind_legal, clock, reset, rsp_valid, kind_ok, "bad source kind")
   `CGE_ASSERT_IMPL(a_black, clock, reset, black_rsp, is_black, "empty table result not black")
   `CGE_ASSERT_IMPL(a_reset_quiet, clock, reset, $past(reset), !busy && !rsp_valid, "not idle")

endmodule

bind color_gradient_evaluator_core cge_checker u_checker (.*);
